/* rtl/uqpd_pkg.sv */
package uqpd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // Raw query characters
  localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CH_EQ      = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_PCT     = 8'h25;  // '%'
  localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] HEX_LETTER = 8'd10;

  // Escape progress
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  // Most results one input word can cause
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned CNT_W     = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_RES);
  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       has_char;
    logic       end_of_query;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_out;
    logic       had_value;
    logic       last;
    logic       query_done;
  } out_word_t;

  // All results of one input word, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    out_word_t [MAX_RES-1:0]   res;
  } bundle_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
             (c >= CH_LA && c <= CH_LF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] up;
    logic [7:0] diff;
    up = c & ~CASE_BIT;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - CH_0;
    end else begin
      diff = up - CH_UA + HEX_LETTER;
    end
    hex_val = diff[3:0];
  endfunction

endpackage

/* rtl/url_query_pair_decoder_core.sv */
// The first result of a word passes through the bundle queue and then the output register.
// Throughput: one input word per cycle while each yields at most one result and the
// queue is not full; the output register delivers one result per cycle while out_ready_i
// is high; the queue (QueueDepth bundles) lets the front accept during output bursts.
// Reset (rst_ni low, asynchronous) returns to reading a name with no escape pending
// and empties the queue and output register.
module url_query_pair_decoder_core #(
  parameter int unsigned QueueDepth = uqpd_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uqpd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uqpd_pkg::out_word_t out_word_o
);

  logic              push, full, pop, q_valid;
  uqpd_pkg::bundle_t push_bundle, head;

  // Classify bytes and build result bundles
  uqpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_word_i     (in_word_i),
    .push_o        (push),
    .push_bundle_o (push_bundle),
    .full_i        (full)
  );

  // Decouple front and back
  uqpd_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_bundle_i (push_bundle),
    .full_o        (full),
    .pop_i         (pop),
    .valid_o       (q_valid),
    .head_o        (head)
  );

  // Serialize bundles onto the output channel
  uqpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/uqpd_front.sv */
module uqpd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uqpd_pkg::in_word_t in_word_i,
  output logic               push_o,
  output uqpd_pkg::bundle_t  push_bundle_o,
  input  logic               full_i
);

  logic       in_value_q, in_value_d;
  logic [1:0] esc_q, esc_d;
  logic [7:0] first_q, first_d;
  logic       accept;

  uqpd_pkg::bundle_t bundle;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode one word into up to four results and the next state
  always_comb begin
    logic [uqpd_pkg::CNT_W-1:0] n;
    logic [7:0]                 c;
    logic [uqpd_pkg::CNT_W-1:0] lst;
    uqpd_pkg::kind_e            dk;
    logic [1:0]                 stage;

    bundle     = '0;
    n          = '0;
    in_value_d = in_value_q;
    esc_d      = esc_q;
    first_d    = first_q;
    c          = in_word_i.char_in;
    dk         = uqpd_pkg::KIND_NAME;
    stage      = uqpd_pkg::ESC_NONE;

    if (in_word_i.has_char) begin
      dk = in_value_d ? uqpd_pkg::KIND_VALUE : uqpd_pkg::KIND_NAME;
      if (esc_d == uqpd_pkg::ESC_PCT && uqpd_pkg::is_hex(c)) begin
        first_d = c;
        esc_d   = uqpd_pkg::ESC_DIGIT;
      end else if (esc_d == uqpd_pkg::ESC_DIGIT && uqpd_pkg::is_hex(c)) begin
        bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind     = dk;
        bundle.res[n[uqpd_pkg::IDX_W-1:0]].byte_out =
          {uqpd_pkg::hex_val(first_d), uqpd_pkg::hex_val(c)};
        n       = n + 1'b1;
        esc_d   = uqpd_pkg::ESC_NONE;
        first_d = '0;
      end else begin
        // broken escape: pending bytes go out literally
        stage = esc_d;
        esc_d = uqpd_pkg::ESC_NONE;
        if (stage != uqpd_pkg::ESC_NONE) begin
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind     = dk;
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].byte_out = uqpd_pkg::CH_PCT;
          n = n + 1'b1;
          if (stage == uqpd_pkg::ESC_DIGIT) begin
            bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind     = dk;
            bundle.res[n[uqpd_pkg::IDX_W-1:0]].byte_out = first_d;
            n = n + 1'b1;
          end
          first_d = '0;
        end
        // plain byte
        if (c == uqpd_pkg::CH_AMP) begin
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind      = uqpd_pkg::KIND_END;
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].had_value = in_value_d;
          n          = n + 1'b1;
          in_value_d = 1'b0;
        end else if (c == uqpd_pkg::CH_EQ && !in_value_d) begin
          in_value_d = 1'b1;
        end else if (c == uqpd_pkg::CH_PCT) begin
          esc_d = uqpd_pkg::ESC_PCT;
        end else begin
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind     = dk;
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].byte_out =
            (c == uqpd_pkg::CH_PLUS) ? uqpd_pkg::CH_SPACE : c;
          n = n + 1'b1;
        end
      end
    end

    // end of query: flush, close the pair, return to reset state
    if (in_word_i.end_of_query) begin
      dk = in_value_d ? uqpd_pkg::KIND_VALUE : uqpd_pkg::KIND_NAME;
      if (esc_d != uqpd_pkg::ESC_NONE) begin
        bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind     = dk;
        bundle.res[n[uqpd_pkg::IDX_W-1:0]].byte_out = uqpd_pkg::CH_PCT;
        n = n + 1'b1;
        if (esc_d == uqpd_pkg::ESC_DIGIT) begin
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind     = dk;
          bundle.res[n[uqpd_pkg::IDX_W-1:0]].byte_out = first_d;
          n = n + 1'b1;
        end
      end
      bundle.res[n[uqpd_pkg::IDX_W-1:0]].kind       = uqpd_pkg::KIND_END;
      bundle.res[n[uqpd_pkg::IDX_W-1:0]].had_value  = in_value_d;
      bundle.res[n[uqpd_pkg::IDX_W-1:0]].query_done = 1'b1;
      n          = n + 1'b1;
      in_value_d = 1'b0;
      esc_d      = uqpd_pkg::ESC_NONE;
      first_d    = '0;
    end

    // mark the final result of this word
    lst = n - 1'b1;
    if (n != '0) begin
      bundle.res[lst[uqpd_pkg::IDX_W-1:0]].last = 1'b1;
    end
    bundle.count = n;
  end

  assign push_o        = accept && (bundle.count != '0);
  assign push_bundle_o = bundle;

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q <= 1'b0;
      esc_q      <= uqpd_pkg::ESC_NONE;
      first_q    <= '0;
    end else if (accept) begin
      in_value_q <= in_value_d;
      esc_q      <= esc_d;
      first_q    <= first_d;
    end
  end

endmodule

/* rtl/uqpd_queue.sv */
module uqpd_queue #(
  parameter int unsigned DEPTH = uqpd_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uqpd_pkg::bundle_t push_bundle_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output uqpd_pkg::bundle_t head_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  uqpd_pkg::bundle_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_pop;

  assign full_o  = (fill_q == FULL_FILL);
  assign valid_o = (fill_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!push_i && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_bundle_i;
    end
  end

endmodule

/* rtl/uqpd_back.sv */
module uqpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  uqpd_pkg::bundle_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uqpd_pkg::out_word_t out_word_o
);

  logic [uqpd_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  uqpd_pkg::out_word_t        out_q;
  logic                       load;
  logic                       at_end;
  logic [uqpd_pkg::CNT_W-1:0] next_cnt;

  // Output register takes a new word when empty or being drained
  assign load     = valid_i && (!out_valid_q || out_ready_i);
  assign next_cnt = {{(uqpd_pkg::CNT_W - uqpd_pkg::IDX_W){1'b0}}, idx_q} + 1'b1;
  assign at_end   = (next_cnt == head_i.count);
  assign pop_o    = load && at_end;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = at_end ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i.res[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* tb/url_query_pair_decoder_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the query pair decoder, predicts the decoded words
// and compares each output word against the oldest prediction.
module url_query_pair_decoder_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  uqpd_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  uqpd_pkg::out_word_t out_word_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Decoder state as the predictor tracks it
  logic       dec_in_value;
  logic [1:0] dec_esc;
  logic [7:0] dec_held_digit;

  uqpd_pkg::out_word_t decoded_q[$];     // predicted words not yet seen on the output
  uqpd_pkg::out_word_t word_results[$];  // words caused by the input word being decoded
  int                  fail_total;

  assign fail_count_o = fail_total;
  assign pending_o    = decoded_q.size();

  function automatic logic digit_ok(input logic [7:0] c);
    return (c >= uqpd_pkg::CH_0 && c <= uqpd_pkg::CH_9) ||
           (c >= uqpd_pkg::CH_UA && c <= uqpd_pkg::CH_UF) ||
           (c >= uqpd_pkg::CH_LA && c <= uqpd_pkg::CH_LF);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= uqpd_pkg::CH_9) begin
      v = c - uqpd_pkg::CH_0;
    end else if (c >= uqpd_pkg::CH_LA) begin
      v = c - uqpd_pkg::CH_LA + 8'd10;
    end else begin
      v = c - uqpd_pkg::CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_total < 50) begin
      $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    end
    fail_total++;
  endtask

  task automatic push_result(input uqpd_pkg::kind_e k, input logic [7:0] b,
                             input logic hv, input logic qd);
    uqpd_pkg::out_word_t r;
    r.kind       = k;
    r.byte_out   = b;
    r.had_value  = hv;
    r.last       = 1'b0;
    r.query_done = qd;
    word_results.push_back(r);
  endtask

  task automatic push_data(input logic [7:0] b);
    push_result(dec_in_value ? uqpd_pkg::KIND_VALUE : uqpd_pkg::KIND_NAME, b, 1'b0, 1'b0);
  endtask

  // Pending '%' (and a held first digit) go out as literal bytes
  task automatic release_escape();
    logic [1:0] stage;
    stage   = dec_esc;
    dec_esc = uqpd_pkg::ESC_NONE;
    if (stage != uqpd_pkg::ESC_NONE) begin
      push_data(uqpd_pkg::CH_PCT);
      if (stage == uqpd_pkg::ESC_DIGIT) begin
        push_data(dec_held_digit);
      end
      dec_held_digit = '0;
    end
  endtask

  task automatic decode_word(input uqpd_pkg::in_word_t w);
    logic [7:0]          c;
    uqpd_pkg::out_word_t tail;
    c = w.char_in;
    word_results.delete();
    if (w.has_char) begin
      if (dec_esc == uqpd_pkg::ESC_PCT && digit_ok(c)) begin
        dec_held_digit = c;
        dec_esc        = uqpd_pkg::ESC_DIGIT;
      end else if (dec_esc == uqpd_pkg::ESC_DIGIT && digit_ok(c)) begin
        push_data({digit_value(dec_held_digit), digit_value(c)});
        dec_esc        = uqpd_pkg::ESC_NONE;
        dec_held_digit = '0;
      end else begin
        release_escape();
        // plain byte handling
        if (c == uqpd_pkg::CH_AMP) begin
          push_result(uqpd_pkg::KIND_END, 8'h00, dec_in_value, 1'b0);
          dec_in_value = 1'b0;
        end else if (c == uqpd_pkg::CH_EQ && !dec_in_value) begin
          dec_in_value = 1'b1;
        end else if (c == uqpd_pkg::CH_PCT) begin
          dec_esc = uqpd_pkg::ESC_PCT;
        end else if (c == uqpd_pkg::CH_PLUS) begin
          push_data(uqpd_pkg::CH_SPACE);
        end else begin
          push_data(c);
        end
      end
    end
    // end of query closes the current pair
    if (w.end_of_query) begin
      release_escape();
      push_result(uqpd_pkg::KIND_END, 8'h00, dec_in_value, 1'b1);
      dec_in_value   = 1'b0;
      dec_esc        = uqpd_pkg::ESC_NONE;
      dec_held_digit = '0;
    end
    if (word_results.size() > 0) begin
      tail      = word_results.pop_back();
      tail.last = 1'b1;
      word_results.push_back(tail);
    end
    foreach (word_results[i]) begin
      decoded_q.push_back(word_results[i]);
    end
  endtask

  task automatic check_word(input uqpd_pkg::out_word_t got);
    uqpd_pkg::out_word_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("unexpected word, byte", got.byte_out, 8'h00);
    end else begin
      want = decoded_q.pop_front();
      if (got.kind != want.kind) begin
        report_mismatch("kind", 8'(got.kind), 8'(want.kind));
      end
      if (got.byte_out != want.byte_out) begin
        report_mismatch("byte_out", got.byte_out, want.byte_out);
      end
      if (got.had_value != want.had_value) begin
        report_mismatch("had_value", 8'(got.had_value), 8'(want.had_value));
      end
      if (got.last != want.last) begin
        report_mismatch("last", 8'(got.last), 8'(want.last));
      end
      if (got.query_done != want.query_done) begin
        report_mismatch("query_done", 8'(got.query_done), 8'(want.query_done));
      end
    end
  endtask

  // Sample both handshakes at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_in_value   = 1'b0;
      dec_esc        = uqpd_pkg::ESC_NONE;
      dec_held_digit = '0;
      decoded_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_word(in_word_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_word(out_word_i);
      end
    end
  end

  initial begin
    fail_total = 0;
  end

endmodule

/* tb/tb_url_query_pair_decoder_core.sv */
`timescale 1ns / 100ps

module tb_url_query_pair_decoder_core;

  localparam int ITEM_TARGET = 450;   // counted input words (byte or end marker)
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int HOLD_AFTER  = 150;   // words taken before the hold-off
  localparam int DRAIN       = 20;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  uqpd_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  uqpd_pkg::out_word_t out_word;
  int                  fail_count;
  int                  pending;

  int        items_sent;
  bit        send_fast;

  url_query_pair_decoder_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  url_query_pair_decoder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic offer_word(input logic [7:0] c, input logic has, input logic eoq);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      send_fast = !send_fast;
    end
    gap = send_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= '{char_in: c, has_char: has, end_of_query: eoq};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (has || eoq) begin
      items_sent++;
    end
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) begin
      return uqpd_pkg::CH_0 + v;
    end
    return ($urandom_range(0, 1) ? uqpd_pkg::CH_LA : uqpd_pkg::CH_UA) + v - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(uqpd_pkg::CH_LA, 8'h7A));
      1:       return 8'($urandom_range(uqpd_pkg::CH_UA, 8'h5A));
      default: return 8'($urandom_range(uqpd_pkg::CH_0, uqpd_pkg::CH_9));
    endcase
  endfunction

  // One piece of name or value text
  task automatic send_text();
    logic [7:0] breakers[7];
    int r;
    breakers = '{uqpd_pkg::CH_AMP, uqpd_pkg::CH_EQ, uqpd_pkg::CH_PCT, uqpd_pkg::CH_PLUS,
                 8'h67, 8'h5A, uqpd_pkg::CH_SPACE};
    r = $urandom_range(0, 99);
    if (r < 50) begin
      offer_word(plain_char(), 1'b1, 1'b0);
    end else if (r < 65) begin
      offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
      offer_word(hex_char(), 1'b1, 1'b0);
      offer_word(hex_char(), 1'b1, 1'b0);
    end else if (r < 70) begin
      // broken escape
      offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
      if ($urandom_range(0, 1)) begin
        offer_word(hex_char(), 1'b1, 1'b0);
      end
      offer_word(breakers[$urandom_range(0, 6)], 1'b1, 1'b0);
    end else if (r < 78) begin
      offer_word(uqpd_pkg::CH_PLUS, 1'b1, 1'b0);
    end else if (r < 84) begin
      offer_word(uqpd_pkg::CH_EQ, 1'b1, 1'b0);
    end else if (r < 94) begin
      offer_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end else begin
      offer_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endtask

  // A well-formed query: pairs split by '&', closed by an end marker
  task automatic send_query();
    int npairs;
    npairs = $urandom_range(1, 4);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) begin
        offer_word(uqpd_pkg::CH_AMP, 1'b1, 1'b0);
      end
      repeat ($urandom_range(0, 4)) send_text();
      if ($urandom_range(0, 9) < 7) begin
        offer_word(uqpd_pkg::CH_EQ, 1'b1, 1'b0);
        repeat ($urandom_range(0, 5)) send_text();
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      offer_word(uqpd_pkg::CH_AMP, 1'b1, 1'b0);
    end
    if ($urandom_range(0, 1)) begin
      offer_word($urandom_range(0, 1) ? hex_char() : plain_char(), 1'b1, 1'b1);
    end else begin
      offer_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // Receiver: random hold-off per word, one long hold-off to back up the block
  initial begin : receiver
    int  gap;
    int  taken;
    bit  fast;
    bit  held_off;
    taken     = 0;
    fast      = 1'b0;
    held_off  = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        fast = !fast;
      end
      gap = fast ? 0 : $urandom_range(0, 10);
      if (!held_off && taken == HOLD_AFTER) begin
        gap      = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("url_query_pair_decoder_core test failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    items_sent = 0;
    send_fast  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty query, then a word that carries nothing
    offer_word(8'h00, 1'b0, 1'b1);
    offer_word(8'hFF, 1'b0, 1'b0);
    // name, value with '+', escapes of both cases, literal second '='
    offer_word(uqpd_pkg::CH_LA, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_EQ, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_PLUS, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_0 + 8'd4, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_0 + 8'd1, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_EQ, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_LF, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_UF, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_AMP, 1'b1, 1'b0);
    // decoded zero byte, broken escape, raw extremes
    offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_0, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_0, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
    offer_word(8'h47, 1'b1, 1'b0);
    offer_word(8'h00, 1'b1, 1'b0);
    offer_word(8'hFF, 1'b1, 1'b0);
    // escape cut by '&', then '=' and a held digit flushed by a final '=' with the end marker
    offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_0 + 8'd7, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_AMP, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_EQ, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_LA, 1'b1, 1'b0);
    offer_word(uqpd_pkg::CH_EQ, 1'b1, 1'b1);
    // end of query with only '%' pending
    offer_word(uqpd_pkg::CH_PCT, 1'b1, 1'b0);
    offer_word(8'h00, 1'b0, 1'b1);

    // random part: mostly well-formed queries, some noise
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 85) begin
        send_query();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 7) == 0);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("url_query_pair_decoder_core test passed");
    end else begin
      $display("url_query_pair_decoder_core test failed");
    end
    $finish;
  end

endmodule

/* url_query_pair_decoder_core.f */
rtl/uqpd_pkg.sv
rtl/uqpd_front.sv
rtl/uqpd_queue.sv
rtl/uqpd_back.sv
rtl/url_query_pair_decoder_core.sv
tb/url_query_pair_decoder_checker.sv
tb/tb_url_query_pair_decoder_core.sv
